// ===== design/ekvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ekvp_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW = $clog2(QueueDepth);
    localparam int MaxResults = 3;

    localparam logic [2:0] K_NAME_BYTE  = 3'd0;
    localparam logic [2:0] K_VALUE_BYTE = 3'd1;
    localparam logic [2:0] K_NAME_DONE  = 3'd2;
    localparam logic [2:0] K_ELEM_DONE  = 3'd3;
    localparam logic [2:0] K_PAIR_DONE  = 3'd4;
    localparam logic [2:0] K_ERROR      = 3'd5;
    localparam logic [2:0] K_ALL_DONE   = 3'd6;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_LETTER    = 3'd1;
    localparam logic [2:0] E_EQUALS    = 3'd2;
    localparam logic [2:0] E_PREMATURE = 3'd3;
    localparam logic [2:0] E_HEX       = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_string;
    } item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [2:0] error_code;
        logic       last;
    } result_t;

    // up to three results caused by one character; cnt is never zero in the queue
    typedef struct packed {
        logic [1:0]             cnt;
        result_t [MaxResults-1:0] res;
    } bundle_t;

    typedef struct packed {
        logic    push;
        bundle_t bundle;
    } push_t;

    typedef struct packed {
        logic    full;
        logic    empty;
        bundle_t head;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== design/escaped_key_value_list_parser.sv =====
// Path: result words are queued, then loaded into the output register.
// Throughput: one character per cycle while the queue is not full and each
// gives at most one word; the single output register sends one word per cycle
// unless result_stall holds it, and a four-entry queue absorbs bursts.
// Reset: parser back to expecting a name letter, queue emptied, no word valid.
`timescale 1ns / 1ps
`default_nettype none

module escaped_key_value_list_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire ekvp_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output ekvp_pkg::result_t      result
);
    import ekvp_pkg::*;

    push_t         push;
    queue_status_t status;
    logic          pop;

    assign item_stall = status.full;

    ekvp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .queue_full (status.full),
        .push       (push)
    );

    ekvp_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (status)
    );

    ekvp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== design/ekvp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ekvp_front
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    input  wire ekvp_pkg::item_t        item,
    input  wire logic                   queue_full,
    output ekvp_pkg::push_t             push
);
    import ekvp_pkg::*;

    typedef enum logic [7:0] {
        PH_NAME_FIRST = 8'b0000_0001,
        PH_NAME_REST  = 8'b0000_0010,
        PH_VALUE      = 8'b0000_0100,
        PH_ESCAPE     = 8'b0000_1000,
        PH_HEX1       = 8'b0001_0000,
        PH_HEX2       = 8'b0010_0000,
        PH_HEX2_BAD   = 8'b0100_0000,
        PH_SKIP       = 8'b1000_0000
    } phase_t;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    phase_t     phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;

    logic       accept;
    logic       is_alpha, is_digit, is_hex;
    logic [3:0] hex_val;
    logic [7:0] c;
    logic       e;
    logic       p_en;
    logic [2:0] p_kind;
    logic [7:0] p_data;
    logic [2:0] err;
    logic       finish;
    bundle_t    b;

    assign c = item.ch;
    assign e = item.end_of_string;
    assign accept = item_valid && !queue_full;

    always_comb
    begin
        is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        is_digit = (c >= 8'h30 && c <= 8'h39);
        is_hex   = 1'b1;
        hex_val  = 4'd0;
        if (is_digit)
        begin
            hex_val = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hex_val = 4'(c - 8'h41 + 8'h0A);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hex_val = 4'(c - 8'h61 + 8'h0A);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        p_en       = 1'b0;
        p_kind     = K_VALUE_BYTE;
        p_data     = 8'd0;
        err        = E_NONE;
        finish     = 1'b0;
        phase_next = phase_reg;
        nib_next   = nib_reg;

        case (phase_reg)
            PH_NAME_FIRST:
            begin
                if (is_alpha)
                begin
                    p_en   = 1'b1;
                    p_kind = K_NAME_BYTE;
                    p_data = c;
                    if (e) err = E_PREMATURE;
                    else   phase_next = PH_NAME_REST;
                end
                else
                begin
                    err = E_LETTER;
                end
            end
            PH_NAME_REST:
            begin
                if (is_alpha || is_digit || c == CH_UNDER)
                begin
                    p_en   = 1'b1;
                    p_kind = K_NAME_BYTE;
                    p_data = c;
                    if (e) err = E_PREMATURE;
                end
                else if (c == CH_EQUALS)
                begin
                    p_en   = 1'b1;
                    p_kind = K_NAME_DONE;
                    if (e) finish = 1'b1;
                    else   phase_next = PH_VALUE;
                end
                else
                begin
                    err = E_EQUALS;
                end
            end
            PH_VALUE:
            begin
                if (c == CH_SEMI)
                begin
                    p_en   = 1'b1;
                    p_kind = K_PAIR_DONE;
                    if (e) err = E_PREMATURE;
                    else   phase_next = PH_NAME_FIRST;
                end
                else if (c == CH_COMMA)
                begin
                    p_en   = 1'b1;
                    p_kind = K_ELEM_DONE;
                    if (e) finish = 1'b1;
                end
                else if (c == CH_BSLASH)
                begin
                    if (e) err = E_PREMATURE;
                    else   phase_next = PH_ESCAPE;
                end
                else
                begin
                    p_en   = 1'b1;
                    p_data = c;
                    if (e) finish = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (c == CH_X)
                begin
                    if (e) err = E_PREMATURE;
                    else   phase_next = PH_HEX1;
                end
                else
                begin
                    if (c == CH_SEMI || c == CH_BSLASH || c == CH_COMMA)
                    begin
                        p_en   = 1'b1;
                        p_data = c;
                    end
                    else if (c == CH_N)
                    begin
                        p_en   = 1'b1;
                        p_data = CH_LF;
                    end
                    else if (c == CH_T)
                    begin
                        p_en   = 1'b1;
                        p_data = CH_TAB;
                    end
                    else if (c == CH_R)
                    begin
                        p_en   = 1'b1;
                        p_data = CH_CR;
                    end
                    if (e) finish = 1'b1;
                    else   phase_next = PH_VALUE;
                end
            end
            PH_HEX1:
            begin
                if (e)
                begin
                    err = E_PREMATURE;
                end
                else if (is_hex)
                begin
                    nib_next   = hex_val;
                    phase_next = PH_HEX2;
                end
                else
                begin
                    nib_next   = 4'd0;
                    phase_next = PH_HEX2_BAD;
                end
            end
            PH_HEX2:
            begin
                if (is_hex)
                begin
                    p_en     = 1'b1;
                    p_data   = {nib_reg, hex_val};
                    nib_next = 4'd0;
                    if (e) finish = 1'b1;
                    else   phase_next = PH_VALUE;
                end
                else
                begin
                    err = E_HEX;
                end
            end
            PH_HEX2_BAD:
            begin
                err = E_HEX;
            end
            PH_SKIP:
            begin
                if (e)
                begin
                    phase_next = PH_NAME_FIRST;
                    nib_next   = 4'd0;
                end
            end
            default:
            begin
                phase_next = PH_NAME_FIRST;
                nib_next   = 4'd0;
            end
        endcase

        if (err != E_NONE)
        begin
            nib_next   = 4'd0;
            phase_next = e ? PH_NAME_FIRST : PH_SKIP;
        end
        else if (finish)
        begin
            nib_next   = 4'd0;
            phase_next = PH_NAME_FIRST;
        end
    end

    // pack results in order: primary, then error or pair/all done
    always_comb
    begin
        b = '0;
        if (p_en)
        begin
            b.res[0].kind      = p_kind;
            b.res[0].data_byte = p_data;
            if (err != E_NONE)
            begin
                b.res[1].kind       = K_ERROR;
                b.res[1].error_code = err;
                b.cnt               = 2'd2;
            end
            else if (finish)
            begin
                b.res[1].kind = K_PAIR_DONE;
                b.res[2].kind = K_ALL_DONE;
                b.cnt         = 2'd3;
            end
            else
            begin
                b.cnt = 2'd1;
            end
        end
        else if (err != E_NONE)
        begin
            b.res[0].kind       = K_ERROR;
            b.res[0].error_code = err;
            b.cnt               = 2'd1;
        end
        else if (finish)
        begin
            b.res[0].kind = K_PAIR_DONE;
            b.res[1].kind = K_ALL_DONE;
            b.cnt         = 2'd2;
        end
    end

    assign push.push   = accept && (b.cnt != 2'd0);
    assign push.bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME_FIRST;
            nib_reg   <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ekvp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ekvp_queue
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ekvp_pkg::push_t         push,
    input  wire logic                    pop,
    output ekvp_pkg::queue_status_t      status
);
    import ekvp_pkg::*;

    bundle_t              slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign status.full  = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign status.empty = (count_reg == '0);
    assign status.head  = slot_reg[rd_ptr_reg];

    assign do_push = push.push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ekvp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ekvp_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ekvp_pkg::queue_status_t status,
    output logic                         pop,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output ekvp_pkg::result_t            result
);
    import ekvp_pkg::*;

    logic [1:0] sub_reg;
    logic       valid_reg;
    result_t    out_reg;
    logic       load;
    logic       final_word;
    result_t    word;

    assign load       = !status.empty && (!valid_reg || !result_stall);
    assign final_word = (sub_reg == status.head.cnt - 2'd1);
    assign pop        = load && final_word;

    always_comb
    begin
        word      = status.head.res[sub_reg];
        word.last = final_word;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                sub_reg <= final_word ? 2'd0 : sub_reg + 2'd1;
            end
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
